### rtl/stsf_pkg.sv
// Shared types and constants for the shaded triangle span fill block.
// No dependencies; every other file but stsf_stream_if uses this package.
package stsf_pkg;

	localparam int SCREEN_W_DEF = 256;
	localparam int SCREEN_H_DEF = 256;

	localparam logic [31:0] BLACK_OPAQUE = 32'h0000_00FF;
	localparam logic [31:0] OFF_SCREEN_COLOR = 32'h0000_0000;

	localparam int MEM_AW = 20;
	localparam int DIV_NW = 28;
	localparam int DIV_DW = 12;

	localparam logic CMD_FILL = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic cmd;
		logic signed [11:0] ax;
		logic signed [11:0] ay;
		logic [31:0] acolor;
		logic signed [11:0] bx;
		logic signed [11:0] by_coord;
		logic [31:0] bcolor;
		logic signed [11:0] cx;
		logic signed [11:0] cy;
		logic [31:0] ccolor;
	} req_t;

	typedef struct packed {
		logic [31:0] read_color;
		logic outside_screen;
	} rsp_t;

	typedef struct packed {
		logic en;
		logic [MEM_AW-1:0] addr;
		logic [31:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic en;
		logic [MEM_AW-1:0] addr;
	} mem_rd_t;

	typedef struct packed {
		logic start;
		logic signed [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic signed [DIV_NW-1:0] quo;
		logic [DIV_DW-1:0] rem;
	} div_rsp_t;

endpackage

### rtl/stsf_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
// Payload type is set per instance; no package dependency.
interface stsf_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/stsf_div.sv
// Radix-2 restoring divider, signed numerator, positive denominator.
// Floored quotient and non-negative remainder. Uses stsf_pkg.
module stsf_div (
	input logic clk,
	input logic arst_n,
	input stsf_pkg::div_req_t req,
	output stsf_pkg::div_rsp_t rsp
);
	import stsf_pkg::*;

	localparam int CW = $clog2(DIV_NW + 1);

	logic [DIV_NW-1:0] mag_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic neg_q;
	logic busy_q;
	logic done_q;
	logic [CW-1:0] cnt_q;

	logic [DIV_DW:0] rem_sh;
	logic fit;

	assign rem_sh = {rem_q, mag_q[DIV_NW-1]};
	assign fit = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !req.start && busy_q && cnt_q == CW'(1);
			if (req.start) begin
				mag_q <= req.num[DIV_NW-1] ? DIV_NW'(-req.num) : DIV_NW'(req.num);
				neg_q <= req.num[DIV_NW-1];
				den_q <= req.den;
				rem_q <= '0;
				cnt_q <= CW'(DIV_NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fit ? DIV_DW'(rem_sh - {1'b0, den_q}) : DIV_DW'(rem_sh);
				mag_q <= {mag_q[DIV_NW-2:0], fit};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		if (neg_q && rem_q != '0) begin
			rsp.quo = -$signed(mag_q) - DIV_NW'(1);
			rsp.rem = den_q - rem_q;
		end else if (neg_q) begin
			rsp.quo = -$signed(mag_q);
			rsp.rem = rem_q;
		end else begin
			rsp.quo = $signed(mag_q);
			rsp.rem = rem_q;
		end
	end
endmodule

### rtl/stsf_fstore.sv
// Frame store: one-write, one-read synchronous RAM with a clearing pass.
// Clears every word to opaque black after reset. Uses stsf_pkg.
module stsf_fstore #(
	parameter int SCREEN_W = stsf_pkg::SCREEN_W_DEF,
	parameter int SCREEN_H = stsf_pkg::SCREEN_H_DEF
) (
	input logic clk,
	input logic arst_n,
	input stsf_pkg::mem_wr_t wr,
	input stsf_pkg::mem_rd_t rd,
	output logic [31:0] rdata,
	output logic clr_busy
);
	import stsf_pkg::*;

	localparam int DEPTH = SCREEN_W * SCREEN_H;
	localparam int AW = $clog2(DEPTH);

	logic [31:0] mem [DEPTH];
	logic [AW-1:0] clr_cnt_q;
	logic clr_busy_q;
	logic [31:0] rdata_q;

	logic we;
	logic [AW-1:0] waddr;
	logic [31:0] wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		we = clr_busy_q || wr.en;
		waddr = clr_busy_q ? clr_cnt_q : wr.addr[AW-1:0];
		wdata = clr_busy_q ? BLACK_OPAQUE : wr.data;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd.en) begin
			rdata_q <= mem[rd.addr[AW-1:0]];
		end
	end

	assign rdata = rdata_q;
	assign clr_busy = clr_busy_q;
endmodule

### rtl/stsf_raster.sv
// Command sequencer: vertex sort, row walk, edge and span interpolation.
// Drives frame store ports and the shared divider. Uses stsf_pkg, stsf_stream_if.
module stsf_raster #(
	parameter int SCREEN_W = stsf_pkg::SCREEN_W_DEF,
	parameter int SCREEN_H = stsf_pkg::SCREEN_H_DEF
) (
	input logic clk,
	input logic arst_n,
	stsf_stream_if.sink req,
	stsf_stream_if.source rsp,
	input logic clr_busy,
	input logic [31:0] rdata,
	output stsf_pkg::mem_wr_t wr,
	output stsf_pkg::mem_rd_t rd,
	output stsf_pkg::div_req_t dreq,
	input stsf_pkg::div_rsp_t drsp
);
	import stsf_pkg::*;

	localparam int XW = $clog2(SCREEN_W);
	localparam int YW = $clog2(SCREEN_H);
	localparam logic signed [12:0] WS = 13'(SCREEN_W);
	localparam logic signed [12:0] HS = 13'(SCREEN_H);

	localparam logic [3:0] K_FL_L = 4'd0;
	localparam logic [3:0] K_FL_S = 4'd1;
	localparam logic [3:0] K_CL0 = 4'd2;
	localparam logic [3:0] K_CL3 = 4'd5;
	localparam logic [3:0] K_CS0 = 4'd6;
	localparam logic [3:0] K_CS3 = 4'd9;
	localparam logic [3:0] K_SP0 = 4'd10;
	localparam logic [3:0] K_SP3 = 4'd13;

	typedef struct packed {
		logic signed [11:0] x;
		logic signed [11:0] y;
		logic [31:0] c;
	} vtx_t;

	typedef enum logic [3:0] {
		IDLE, RD_WAIT, ROW, NUM_L, NUM_S, MUL_L, MUL_S,
		DIV_GO, DIV_WAIT, SETUP, SPAN
	} state_t;

	state_t state_q;
	vtx_t v0_q, v1_q, v2_q, s_q, e_q;
	logic signed [11:0] y_q;
	logic [11:0] n1_q, d1_q, n2_q, d2_q;
	logic signed [DIV_NW-1:0] num_l_q, num_s_q;
	logic signed [40:0] pl_q, ps_q;
	logic [3:0] k_q;
	logic signed [12:0] fl_l_q, fl_s_q;
	logic [3:0][7:0] coll_q, cols_q, cl_q, cr_q;
	logic signed [12:0] x_q, xr_q;
	logic [11:0] dd_q;
	logic signed [9:0] q_q [4];
	logic signed [9:0] qd_q [4];
	logic [11:0] r_q [4];
	logic [11:0] rd_q [4];
	logic out_valid_q;
	rsp_t out_q;

	vtx_t pa, pb, pc, tv;
	logic accept, rd_off, out_set;
	logic row_last, in_rows, upper;
	vtx_t s_c, e_c;
	logic [1:0] chi;
	logic signed [8:0] dl_long, dl_short, dl_span;
	logic ll, fl_lt, span_skip, span_last;
	logic signed [12:0] xl_c, xr_c;
	logic [3:0][7:0] cleft, cright, pix;
	logic [12:0] rn [4];
	logic [3:0] carry;

	always_comb begin
		tv = '0;
		pa = '{x: req.data.ax, y: req.data.ay, c: req.data.acolor};
		pb = '{x: req.data.bx, y: req.data.by_coord, c: req.data.bcolor};
		pc = '{x: req.data.cx, y: req.data.cy, c: req.data.ccolor};
		if (pa.y > pb.y) begin
			tv = pa; pa = pb; pb = tv;
		end
		if (pa.y > pc.y) begin
			tv = pa; pa = pc; pc = tv;
		end
		if (pb.y > pc.y) begin
			tv = pb; pb = pc; pc = tv;
		end
	end

	assign req.ready = (state_q == IDLE) && !clr_busy && (!out_valid_q || rsp.ready);
	assign accept = req.valid && req.ready;
	assign rd_off = req.data.ax < 12'sd0 || 13'(req.data.ax) >= WS ||
		req.data.ay < 12'sd0 || 13'(req.data.ay) >= HS;
	assign out_set = (state_q == RD_WAIT) ||
		(state_q == IDLE && accept && req.data.cmd == CMD_READ && rd_off);

	always_comb begin
		rd.en = accept && req.data.cmd == CMD_READ && !rd_off;
		rd.addr = MEM_AW'(req.data.ay[YW-1:0]) * MEM_AW'(SCREEN_W) +
			MEM_AW'(req.data.ax[XW-1:0]);
	end

	assign row_last = y_q == v2_q.y;
	assign in_rows = y_q >= 12'sd0 && 13'(y_q) < HS;
	assign upper = y_q < v1_q.y;
	assign s_c = upper ? v0_q : v1_q;
	assign e_c = upper ? v1_q : v2_q;

	assign chi = 2'(k_q - K_CL0);
	assign dl_long = 9'({1'b0, v2_q.c[8*chi +: 8]}) - 9'({1'b0, v0_q.c[8*chi +: 8]});
	assign dl_short = 9'({1'b0, e_q.c[8*chi +: 8]}) - 9'({1'b0, s_q.c[8*chi +: 8]});
	assign dl_span = 9'({1'b0, cr_q[chi]}) - 9'({1'b0, cl_q[chi]});

	always_comb begin
		dreq.start = state_q == DIV_GO;
		case (k_q) inside
			K_FL_L: begin
				dreq.num = num_l_q;
				dreq.den = d1_q;
			end
			K_FL_S: begin
				dreq.num = num_s_q;
				dreq.den = d2_q;
			end
			[K_CL0:K_CL3]: begin
				dreq.num = DIV_NW'(dl_long) * DIV_NW'(signed'({1'b0, n1_q}));
				dreq.den = d1_q;
			end
			[K_CS0:K_CS3]: begin
				dreq.num = DIV_NW'(dl_short) * DIV_NW'(signed'({1'b0, n2_q}));
				dreq.den = d2_q;
			end
			default: begin
				dreq.num = DIV_NW'(dl_span);
				dreq.den = dd_q;
			end
		endcase
	end

	assign ll = pl_q < ps_q;
	assign fl_lt = fl_l_q < fl_s_q;
	assign xl_c = fl_lt ? fl_l_q : fl_s_q;
	assign xr_c = fl_lt ? fl_s_q : fl_l_q;
	assign cleft = ll ? coll_q : cols_q;
	assign cright = ll ? cols_q : coll_q;
	assign span_skip = xr_c < 13'sd0 || xl_c >= WS;
	assign span_last = x_q == xr_q || x_q == WS - 13'sd1;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pix[i] = cl_q[i] + q_q[i][7:0];
			rn[i] = 13'(r_q[i]) + 13'(rd_q[i]);
			carry[i] = rn[i] >= 13'(dd_q);
		end
		wr.en = state_q == SPAN && x_q >= 13'sd0;
		wr.addr = MEM_AW'(y_q[YW-1:0]) * MEM_AW'(SCREEN_W) + MEM_AW'(x_q[XW-1:0]);
		wr.data = pix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			out_valid_q <= 1'b0;
			k_q <= K_FL_L;
		end else begin
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (accept && req.data.cmd == CMD_READ) begin
						if (rd_off) begin
							out_q <= '{read_color: OFF_SCREEN_COLOR, outside_screen: 1'b1};
						end else begin
							state_q <= RD_WAIT;
						end
					end else if (accept && pa.y != pc.y) begin
						v0_q <= pa;
						v1_q <= pb;
						v2_q <= pc;
						y_q <= pa.y;
						state_q <= ROW;
					end
				end
				RD_WAIT: begin
					out_q <= '{read_color: rdata, outside_screen: 1'b0};
					state_q <= IDLE;
				end
				ROW: begin
					if (!in_rows || e_c.y == s_c.y) begin
						if (row_last) begin
							state_q <= IDLE;
						end else begin
							y_q <= y_q + 12'sd1;
						end
					end else begin
						s_q <= s_c;
						e_q <= e_c;
						n1_q <= 12'(13'(y_q) - 13'(v0_q.y));
						d1_q <= 12'(13'(v2_q.y) - 13'(v0_q.y));
						n2_q <= 12'(13'(y_q) - 13'(s_c.y));
						d2_q <= 12'(13'(e_c.y) - 13'(s_c.y));
						state_q <= NUM_L;
					end
				end
				NUM_L: begin
					num_l_q <= DIV_NW'(v0_q.x) * DIV_NW'(signed'({1'b0, d1_q})) +
						(DIV_NW'(v2_q.x) - DIV_NW'(v0_q.x)) * DIV_NW'(signed'({1'b0, n1_q}));
					state_q <= NUM_S;
				end
				NUM_S: begin
					num_s_q <= DIV_NW'(s_q.x) * DIV_NW'(signed'({1'b0, d2_q})) +
						(DIV_NW'(e_q.x) - DIV_NW'(s_q.x)) * DIV_NW'(signed'({1'b0, n2_q}));
					state_q <= MUL_L;
				end
				MUL_L: begin
					pl_q <= 41'(num_l_q) * 41'(signed'({1'b0, d2_q}));
					state_q <= MUL_S;
				end
				MUL_S: begin
					ps_q <= 41'(num_s_q) * 41'(signed'({1'b0, d1_q}));
					k_q <= K_FL_L;
					state_q <= DIV_GO;
				end
				DIV_GO: begin
					state_q <= DIV_WAIT;
				end
				DIV_WAIT: begin
					if (drsp.done) begin
						case (k_q) inside
							K_FL_L: fl_l_q <= 13'(drsp.quo);
							K_FL_S: fl_s_q <= 13'(drsp.quo);
							[K_CL0:K_CL3]: coll_q[chi] <= v0_q.c[8*chi +: 8] + drsp.quo[7:0];
							[K_CS0:K_CS3]: cols_q[chi] <= s_q.c[8*chi +: 8] + drsp.quo[7:0];
							default: begin
								qd_q[chi] <= 10'(drsp.quo);
								rd_q[chi] <= drsp.rem;
							end
						endcase
						if (k_q == K_CS3) begin
							state_q <= SETUP;
						end else if (k_q == K_SP3) begin
							state_q <= SPAN;
						end else begin
							k_q <= k_q + 4'd1;
							state_q <= DIV_GO;
						end
					end
				end
				SETUP: begin
					cl_q <= cleft;
					cr_q <= cright;
					x_q <= xl_c;
					xr_q <= xr_c;
					dd_q <= (xl_c == xr_c) ? 12'd1 : 12'(xr_c - xl_c);
					for (int i = 0; i < 4; i++) begin
						q_q[i] <= '0;
						r_q[i] <= '0;
						qd_q[i] <= '0;
						rd_q[i] <= '0;
					end
					if (span_skip) begin
						if (row_last) begin
							state_q <= IDLE;
						end else begin
							y_q <= y_q + 12'sd1;
							state_q <= ROW;
						end
					end else if (xl_c == xr_c) begin
						state_q <= SPAN;
					end else begin
						k_q <= K_SP0;
						state_q <= DIV_GO;
					end
				end
				SPAN: begin
					x_q <= x_q + 13'sd1;
					for (int i = 0; i < 4; i++) begin
						q_q[i] <= q_q[i] + qd_q[i] + (carry[i] ? 10'sd1 : 10'sd0);
						r_q[i] <= carry[i] ? 12'(rn[i] - 13'(dd_q)) : 12'(rn[i]);
					end
					if (span_last) begin
						if (row_last) begin
							state_q <= IDLE;
						end else begin
							y_q <= y_q + 12'sd1;
							state_q <= ROW;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data = out_q;
endmodule

### rtl/shaded_triangle_span_fill.sv
// Top level of the shaded triangle span fill block.
// Instantiates stsf_raster, stsf_div and stsf_fstore; uses stsf_pkg, stsf_stream_if.
//
// Each request beat is either a Gouraud-shaded triangle fill (no response) or a
// pixel read (one response beat). After reset the frame store runs a clearing
// pass over all SCREEN_W*SCREEN_H words, writing opaque black, and the block
// takes no request until it ends. A read returns the registered frame store
// word. A fill of zero height writes nothing. Rows off screen are skipped; each
// visible row takes up to 14 passes of the shared divider (edge x, edge colors,
// span color steps) and then writes each pixel from the left edge to the
// clipped right edge.
module shaded_triangle_span_fill #(
	parameter int SCREEN_W = stsf_pkg::SCREEN_W_DEF,
	parameter int SCREEN_H = stsf_pkg::SCREEN_H_DEF
) (
	input logic clk,
	input logic arst_n,
	stsf_stream_if.sink req,
	stsf_stream_if.source rsp
);
	import stsf_pkg::*;

	mem_wr_t wr;
	mem_rd_t rd;
	logic [31:0] rdata;
	logic clr_busy;
	div_req_t dreq;
	div_rsp_t drsp;

	stsf_raster #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_raster (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.clr_busy(clr_busy),
		.rdata(rdata),
		.wr(wr),
		.rd(rd),
		.dreq(dreq),
		.drsp(drsp)
	);

	stsf_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.rsp(drsp)
	);

	stsf_fstore #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_fstore (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.rd(rd),
		.rdata(rdata),
		.clr_busy(clr_busy)
	);
endmodule
